// ----- rtl/core/acs_pkg.sv -----
// shared types and constants for the configuration-record to start-code stream block
// no dependencies; imported by every module of the block
package acs_pkg;

  // queue between front and back
  localparam int unsigned ACS_QUEUE_DEPTH = 4;

  // start code: three zero bytes then one
  localparam int unsigned START_LEN  = 4;
  localparam logic [7:0]  START_ZERO = 8'h00;
  localparam logic [7:0]  START_TAIL = 8'h01;

  // header bytes skipped before the sps count
  localparam int unsigned HEADER_LEN = 5;

  // result kinds
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // end-of-record status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_TRAIL = 2'd2;

  // work codes passed from front to back
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_START = 2'd1,
    OP_DATA  = 2'd2
  } op_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  out_byte;
    logic        unit_end;
    logic [16:0] unit_length;
    logic [1:0]  status;
    logic        run_last;
  } out_item_t;

  // one classified input item, expanded by the back part
  typedef struct packed {
    op_t         op;
    logic [7:0]  data_byte;
    logic        unit_end;
    logic [16:0] unit_length;
    logic        has_status;
    logic [1:0]  status;
  } cmd_t;

endpackage

// ----- rtl/core/avc_config_to_start_code_stream_top.sv -----
// top level of the configuration-record to start-code stream block
// depends on acs_pkg, acs_front, acs_queue, acs_back
//
// Takes an H.264 decoder configuration record one byte per item on the in_*
// channel and produces the start-code byte stream on the out_* channel.
// Five header bytes are skipped, then each sps and pps unit comes out as
// 00 00 00 01 followed by its payload; the last byte of a unit carries
// unit_end and the unit length plus four. An input item with in_last set adds
// one status item (ok, truncated or trailing) and returns the parser to its
// reset state for the next record. Header, count and length high bytes make
// no output, a length low byte gives the start code; run_last marks the last
// output item of each input item. With the queue empty, the first output item
// of an input item passes through the queue and then the output register.
// Throughput: one input item per cycle while the queue has room; a length
// low byte expands to four start code items, so the output port, at one item per
// cycle while the receiver is ready, sets the sustained rate and the queue absorbs the bursts.
// Reset clears the parser, the queue and the output valid flag. When the
// receiver stalls the output item holds, the queue fills and in_ready drops.
module avc_config_to_start_code_stream_top #(
  parameter int unsigned QUEUE_DEPTH = acs_pkg::ACS_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  acs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output acs_pkg::out_item_t out_data
);
  import acs_pkg::*;

  logic accept, push, full, pop, nonempty;
  cmd_t push_cmd, head;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  acs_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_item (in_data),
    .push    (push),
    .cmd     (push_cmd)
  );

  acs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .nonempty (nonempty),
    .head     (head)
  );

  acs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (nonempty),
    .cmd       (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/core/acs_front.sv -----
// front part: parses the record byte by byte and classifies each item into a command
// depends on acs_pkg
module acs_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  acs_pkg::in_item_t in_item,
  output logic             push,
  output acs_pkg::cmd_t    cmd
);
  import acs_pkg::*;

  typedef enum logic [3:0] {
    PH_HEADER, PH_SPS_COUNT, PH_SPS_LEN_H, PH_SPS_LEN_L, PH_SPS_DATA,
    PH_PPS_COUNT, PH_PPS_LEN_H, PH_PPS_LEN_L, PH_PPS_DATA, PH_DONE, PH_TRAIL
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  header_index, header_index_next;
  logic [4:0]  units_left, units_left_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [15:0] unit_size, unit_size_next;
  logic [7:0]  length_high, length_high_next;

  logic [15:0] size_now;
  logic [15:0] bytes_dec;
  logic [4:0]  units_dec;
  logic        is_pps;

  assign size_now  = {length_high, in_item.in_byte};
  assign bytes_dec = bytes_left - 16'd1;
  assign units_dec = units_left - 5'd1;
  assign is_pps    = (phase == PH_PPS_LEN_L) || (phase == PH_PPS_DATA);

  // next state and command for the current byte
  always_comb begin
    phase_next        = phase;
    header_index_next = header_index;
    units_left_next   = units_left;
    bytes_left_next   = bytes_left;
    unit_size_next    = unit_size;
    length_high_next  = length_high;
    cmd               = '0;
    cmd.op            = OP_NONE;

    unique case (phase)
      PH_HEADER: begin
        if (header_index == 3'(HEADER_LEN - 1)) begin
          header_index_next = '0;
          phase_next        = PH_SPS_COUNT;
        end else begin
          header_index_next = header_index + 3'd1;
        end
      end
      PH_SPS_COUNT, PH_PPS_COUNT: begin
        units_left_next = in_item.in_byte[4:0];
        if (in_item.in_byte[4:0] == 5'd0) begin
          phase_next = (phase == PH_PPS_COUNT) ? PH_DONE : PH_PPS_COUNT;
        end else begin
          phase_next = (phase == PH_PPS_COUNT) ? PH_PPS_LEN_H : PH_SPS_LEN_H;
        end
      end
      PH_SPS_LEN_H, PH_PPS_LEN_H: begin
        length_high_next = in_item.in_byte;
        phase_next = (phase == PH_PPS_LEN_H) ? PH_PPS_LEN_L : PH_SPS_LEN_L;
      end
      PH_SPS_LEN_L, PH_PPS_LEN_L: begin
        unit_size_next   = size_now;
        bytes_left_next  = size_now;
        cmd.op           = OP_START;
        cmd.unit_end     = (size_now == 16'd0);
        cmd.unit_length  = 17'(START_LEN);
        if (size_now == 16'd0) begin
          units_left_next = units_dec;
          if (units_dec == 5'd0) phase_next = is_pps ? PH_DONE : PH_PPS_COUNT;
          else                   phase_next = is_pps ? PH_PPS_LEN_H : PH_SPS_LEN_H;
        end else begin
          phase_next = is_pps ? PH_PPS_DATA : PH_SPS_DATA;
        end
      end
      PH_SPS_DATA, PH_PPS_DATA: begin
        bytes_left_next = bytes_dec;
        cmd.op          = OP_DATA;
        cmd.data_byte   = in_item.in_byte;
        cmd.unit_end    = (bytes_dec == 16'd0);
        cmd.unit_length = {1'b0, unit_size} + 17'(START_LEN);
        if (bytes_dec == 16'd0) begin
          units_left_next = units_dec;
          if (units_dec == 5'd0) phase_next = is_pps ? PH_DONE : PH_PPS_COUNT;
          else                   phase_next = is_pps ? PH_PPS_LEN_H : PH_SPS_LEN_H;
        end
      end
      default: begin
        phase_next = PH_TRAIL;
      end
    endcase

    // end of buffer: status item, then back to the reset state
    if (in_item.in_last) begin
      cmd.has_status = 1'b1;
      if (phase_next == PH_DONE)       cmd.status = ST_OK;
      else if (phase_next == PH_TRAIL) cmd.status = ST_TRAIL;
      else                             cmd.status = ST_TRUNC;
      phase_next        = PH_HEADER;
      header_index_next = '0;
      units_left_next   = '0;
      bytes_left_next   = '0;
      unit_size_next    = '0;
      length_high_next  = '0;
    end
  end

  assign push = accept && ((cmd.op != OP_NONE) || cmd.has_status);

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_index <= '0;
      units_left   <= '0;
      bytes_left   <= '0;
      unit_size    <= '0;
      length_high  <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      header_index <= header_index_next;
      units_left   <= units_left_next;
      bytes_left   <= bytes_left_next;
      unit_size    <= unit_size_next;
      length_high  <= length_high_next;
    end
  end

endmodule

// ----- rtl/core/acs_queue.sv -----
// short command queue between the front and back parts
// depends on acs_pkg
module acs_queue #(
  parameter int unsigned DEPTH = acs_pkg::ACS_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  acs_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          nonempty,
  output acs_pkg::cmd_t head
);
  import acs_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);
  assign head     = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop)      count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

endmodule

// ----- rtl/core/acs_back.sv -----
// back part: expands queued commands into output items through a registered output stage
// depends on acs_pkg
module acs_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  acs_pkg::cmd_t      cmd,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output acs_pkg::out_item_t out_data
);
  import acs_pkg::*;

  logic [2:0] idx;
  logic [2:0] n_stream, n_total;
  logic       fire, last_one;
  out_item_t  item;

  assign n_stream = (cmd.op == OP_START) ? 3'(START_LEN) :
                    (cmd.op == OP_DATA)  ? 3'd1 : 3'd0;
  assign n_total  = n_stream + {2'b0, cmd.has_status};
  assign last_one = (idx == n_total - 3'd1);
  assign fire     = cmd_valid && (!out_valid || out_ready);
  assign pop      = fire && last_one;

  // build the item at the current position of the command
  always_comb begin
    item          = '0;
    item.run_last = last_one;
    if (idx < n_stream) begin
      item.kind = KIND_BYTE;
      if (cmd.op == OP_START) begin
        item.out_byte = (idx == 3'(START_LEN - 1)) ? START_TAIL : START_ZERO;
        item.unit_end = (idx == 3'(START_LEN - 1)) && cmd.unit_end;
      end else begin
        item.out_byte = cmd.data_byte;
        item.unit_end = cmd.unit_end;
      end
      item.unit_length = item.unit_end ? cmd.unit_length : '0;
    end else begin
      item.kind   = KIND_STATUS;
      item.status = cmd.status;
    end
  end

  // output register and position within the command
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (fire) begin
      out_valid <= 1'b1;
      idx       <= last_one ? 3'd0 : idx + 3'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_data <= item;
  end

endmodule

// ----- rtl/core/acs_checker.sv -----
// port-level checks for the start-code stream block, bound to its top level
// depends on acs_pkg and avc_config_to_start_code_stream_top
module acs_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input acs_pkg::out_item_t out_data
);
  import acs_pkg::*;

  // output stage comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // a stalled output item is held
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output item changed");

  // a status item always closes its input item
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_STATUS |-> out_data.run_last && !out_data.unit_end)
    else $error("status item without run_last");

  // unit end only on stream bytes, with at least the start code length
  a_unit_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.unit_end |->
      out_data.kind == KIND_BYTE && out_data.unit_length >= 17'(START_LEN))
    else $error("bad unit length at unit end");

  // stream bytes carry an ok status and no length outside a unit end
  a_byte_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_BYTE && !out_data.unit_end |->
      out_data.status == ST_OK && out_data.unit_length == 17'd0)
    else $error("stray fields on stream byte");

endmodule

bind avc_config_to_start_code_stream_top acs_checker u_acs_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- dv/acs_stream_checker.sv -----
// checker for the configuration-record to start-code stream block
// depends on acs_pkg; watches both channels, predicts every output item and
// compares it field by field, handing the mismatch count back to the testbench
module acs_stream_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  acs_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  acs_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 expected_left,
  output int                 checked_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import acs_pkg::*;

  // where the parser stands inside one record
  typedef enum logic [3:0] {
    REC_HEADER,
    REC_SPS_COUNT,
    REC_SPS_LEN_HI,
    REC_SPS_LEN_LO,
    REC_SPS_DATA,
    REC_PPS_COUNT,
    REC_PPS_LEN_HI,
    REC_PPS_LEN_LO,
    REC_PPS_DATA,
    REC_DONE,
    REC_TRAIL
  } rec_phase_t;

  // predicted parser state
  rec_phase_t  rec_phase = REC_HEADER;
  logic [2:0]  hdr_count = '0;
  logic [4:0]  units_left = '0;
  logic [15:0] bytes_left = '0;
  logic [15:0] unit_size = '0;
  logic [7:0]  len_hi = '0;

  // output items predicted but not yet seen
  out_item_t stream_expect [$];
  out_item_t oldest;
  int        bad_fields;
  int        mismatches = 0;
  int        matched = 0;

  assign fail_count    = mismatches;
  assign expected_left = stream_expect.size();
  assign checked_count = matched;

  function automatic void clear_parser();
    rec_phase  = REC_HEADER;
    hdr_count  = '0;
    units_left = '0;
    bytes_left = '0;
    unit_size  = '0;
    len_hi     = '0;
  endfunction

  function automatic void queue_result(logic kind, logic [7:0] b, logic unit_end,
                                       logic [16:0] len, logic [1:0] st);
    out_item_t r;
    r.kind        = kind;
    r.out_byte    = b;
    r.unit_end    = unit_end;
    r.unit_length = unit_end ? len : '0;
    r.status      = st;
    r.run_last    = 1'b0;
    stream_expect.push_back(r);
  endfunction

  // unit fully emitted: next unit, next set, or record complete
  function automatic void close_unit(logic is_pps);
    units_left = units_left - 5'd1;
    if (units_left == '0)
      rec_phase = is_pps ? REC_DONE : REC_PPS_COUNT;
    else
      rec_phase = is_pps ? REC_PPS_LEN_HI : REC_SPS_LEN_HI;
  endfunction

  // unit count from the low five bits; zero skips the set
  function automatic void take_count(logic [7:0] b, logic is_pps);
    units_left = b[4:0];
    if (units_left == '0)
      rec_phase = is_pps ? REC_DONE : REC_PPS_COUNT;
    else
      rec_phase = is_pps ? REC_PPS_LEN_HI : REC_SPS_LEN_HI;
  endfunction

  // work out every output item caused by one input item
  function automatic void predict_byte(in_item_t it);
    int         first;
    logic       is_pps;
    logic [1:0] st;
    out_item_t  tail;
    first = stream_expect.size();
    case (rec_phase)
      REC_HEADER: begin
        hdr_count = hdr_count + 3'd1;
        if (hdr_count >= HEADER_LEN) begin
          hdr_count = '0;
          rec_phase = REC_SPS_COUNT;
        end
      end
      REC_SPS_COUNT: take_count(it.in_byte, 1'b0);
      REC_PPS_COUNT: take_count(it.in_byte, 1'b1);
      REC_SPS_LEN_HI, REC_PPS_LEN_HI: begin
        len_hi    = it.in_byte;
        rec_phase = (rec_phase == REC_SPS_LEN_HI) ? REC_SPS_LEN_LO : REC_PPS_LEN_LO;
      end
      REC_SPS_LEN_LO, REC_PPS_LEN_LO: begin
        is_pps     = (rec_phase == REC_PPS_LEN_LO);
        unit_size  = {len_hi, it.in_byte};
        bytes_left = unit_size;
        // start code goes out at once; an empty unit ends on its last byte
        for (int i = 0; i < START_LEN; i++)
          queue_result(KIND_BYTE, (i == START_LEN - 1) ? START_TAIL : START_ZERO,
                       (i == START_LEN - 1) && (unit_size == '0), 17'd4, ST_OK);
        if (unit_size == '0)
          close_unit(is_pps);
        else
          rec_phase = is_pps ? REC_PPS_DATA : REC_SPS_DATA;
      end
      REC_SPS_DATA, REC_PPS_DATA: begin
        is_pps     = (rec_phase == REC_PPS_DATA);
        bytes_left = bytes_left - 16'd1;
        queue_result(KIND_BYTE, it.in_byte, bytes_left == '0,
                     {1'b0, unit_size} + 17'd4, ST_OK);
        if (bytes_left == '0)
          close_unit(is_pps);
      end
      default: rec_phase = REC_TRAIL;
    endcase

    // end of buffer: status item, then back to a fresh record
    if (it.in_last) begin
      if (rec_phase == REC_DONE)
        st = ST_OK;
      else if (rec_phase == REC_TRAIL)
        st = ST_TRAIL;
      else
        st = ST_TRUNC;
      queue_result(KIND_STATUS, 8'h00, 1'b0, '0, st);
      clear_parser();
    end

    // mark the final item of this run
    if (stream_expect.size() > first) begin
      tail = stream_expect.pop_back();
      tail.run_last = 1'b1;
      stream_expect.push_back(tail);
    end
  endfunction

  function automatic int field_diff(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v == got_v)
      return 0;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
    return 1;
  endfunction

  // sample both channels at the edge where items are accepted
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        predict_byte(in_data);
      if (out_valid && out_ready) begin
        if (stream_expect.size() == 0) begin
          $display("%0t: output item %h arrived with nothing expected", $time, out_data);
          mismatches++;
        end else begin
          oldest = stream_expect.pop_front();
          bad_fields = field_diff("kind", oldest.kind, out_data.kind)
                     + field_diff("out_byte", oldest.out_byte, out_data.out_byte)
                     + field_diff("unit_end", oldest.unit_end, out_data.unit_end)
                     + field_diff("unit_length", oldest.unit_length, out_data.unit_length)
                     + field_diff("status", oldest.status, out_data.status)
                     + field_diff("run_last", oldest.run_last, out_data.run_last);
          if (bad_fields != 0)
            mismatches++;
          matched++;
        end
      end
    end
  end

endmodule

// ----- dv/avc_config_to_start_code_stream_top_tb.sv -----
// testbench top for the configuration-record to start-code stream block
// depends on acs_pkg, the block's rtl and acs_stream_checker; drives records
// with random idling on both sides and gives the verdict
module avc_config_to_start_code_stream_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import acs_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int TARGET_ITEMS = 170;
  localparam int DRAIN_CYCLES = 8;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int fail_count;
  int expected_left;
  int checked_count;

  int in_idle_pct = 24;
  int out_idle_pct = 24;
  int items_sent = 0;
  int records_sent = 0;
  int quiet_cycles = 0;

  // bytes of the record buffer being sent
  logic [7:0] rec_q [$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  avc_config_to_start_code_stream_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  acs_stream_checker stream_chk (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .expected_left (expected_left),
    .checked_count (checked_count)
  );

  // receiver stalls at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles without an accepted item", quiet_cycles);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // send the buffer, in_last on its final byte
  task automatic send_record();
    for (int i = 0; i < rec_q.size(); i++) begin
      // no idling on either side over a stretch in the middle of the run
      if (items_sent >= 80 && items_sent < 120) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct  = 24;
        out_idle_pct = 24;
      end
      while ($urandom_range(99) < in_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= '{in_byte: rec_q[i], in_last: (i == rec_q.size() - 1)};
      do @(posedge clk); while (!in_ready);
      items_sent++;
    end
    records_sent++;
  endtask

  // count byte then units, each with a big-endian length and payload
  task automatic append_unit_set();
    int          n_units;
    logic [15:0] len;
    n_units = ($urandom_range(15) == 0) ? $urandom_range(4, 31) : $urandom_range(0, 3);
    rec_q.push_back({3'($urandom), 5'(n_units)});
    repeat (n_units) begin
      len = ($urandom_range(49) == 0) ? 16'($urandom_range(256, 270))
                                      : 16'($urandom_range(0, 8));
      rec_q.push_back(len[15:8]);
      rec_q.push_back(len[7:0]);
      repeat (len) rec_q.push_back(8'($urandom));
    end
  endtask

  // mostly well-formed records, some with trailing bytes, cut short, or noise
  task automatic build_random_record();
    int shape;
    int keep;
    rec_q.delete();
    repeat (HEADER_LEN) rec_q.push_back(8'($urandom));
    append_unit_set();
    append_unit_set();
    shape = $urandom_range(99);
    if (shape >= 60 && shape < 75) begin
      repeat ($urandom_range(1, 3)) rec_q.push_back(8'($urandom));
    end else if (shape >= 75 && shape < 90) begin
      keep = $urandom_range(1, rec_q.size() - 1);
      while (rec_q.size() > keep) void'(rec_q.pop_back());
    end else if (shape >= 90) begin
      rec_q.delete();
      repeat ($urandom_range(1, 12)) rec_q.push_back(8'($urandom));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty sps set, empty pps unit, one trailing byte
    rec_q = '{8'h01, 8'h64, 8'h00, 8'h1f, 8'hff, 8'he0, 8'h01, 8'h00, 8'h00, 8'h55};
    send_record();
    // one short sps unit with extreme payload bytes, empty pps set, ends exactly
    rec_q = '{8'h01, 8'h4d, 8'h40, 8'h1e, 8'hff, 8'h21, 8'h00, 8'h02, 8'h00, 8'hff,
              8'h00};
    send_record();
    // largest length, cut off right after the start code
    rec_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hff, 8'hff};
    send_record();
    // buffer ending inside the header
    rec_q = '{8'h80};
    send_record();

    // random records
    while (items_sent < TARGET_ITEMS) begin
      build_random_record();
      send_record();
    end
    in_valid <= 1'b0;

    // drain, then verdict
    while (expected_left != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_left != 0)
      $display("%0d expected output items never arrived", expected_left);
    $display("sent %0d records in %0d input items; %0d output items compared",
             records_sent, items_sent, checked_count);
    if (fail_count == 0 && expected_left == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/acs_pkg.sv
rtl/core/acs_front.sv
rtl/core/acs_queue.sv
rtl/core/acs_back.sv
rtl/core/avc_config_to_start_code_stream_top.sv
rtl/core/acs_checker.sv
dv/acs_stream_checker.sv
dv/avc_config_to_start_code_stream_top_tb.sv
